// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the encryptor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ===== hw/rtl/pfe_pkg.sv =====
// Shared types, constants and helper functions of the Playfair pair encryptor.
// Depends on nothing; imported by the front, back and top-level modules.
package pfe_pkg;

  localparam int NUM_LETTERS = 26;
  localparam int NUM_CELLS = 25;
  localparam int JOB_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam logic [4:0] LETTER_Q = 5'd16;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_LAST = 5'd25;
  localparam logic [2:0] SIDE_LAST = 3'd5;
  localparam logic [2:0] SIDE_END = 3'd6;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CHAR_LOWER_Q = 8'd113;
  localparam logic [6:0] CHAR_UPPER_A = 7'd65;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_KEY      = 3'd1,
    CMD_KEY_DONE = 3'd2,
    CMD_TEXT     = 3'd3,
    CMD_END      = 3'd4
  } pfe_cmd_t;

  typedef enum logic {
    FS_RUN,
    FS_FILL
  } pfe_front_state_t;

  typedef struct packed {
    logic [4:0] first;
    logic [4:0] second;
    logic       sq_full;
  } pfe_job_t;

  typedef struct packed {
    logic       we;
    logic [4:0] letter;
    logic [5:0] pos;
    logic [4:0] slot;
  } pfe_wr_t;

  typedef struct packed {
    logic [6:0] cipher_first;
    logic [6:0] cipher_second;
  } pfe_res_t;

  function automatic logic [2:0] wrap_next(input logic [2:0] v);
    return (v >= SIDE_LAST) ? 3'd1 : 3'(v + 3'd1);
  endfunction

  function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
    logic [4:0] rm;
    rm = 5'(r) - 5'd1;
    return 5'((rm << 2) + rm + 5'(c) - 5'd1);
  endfunction

  function automatic logic [6:0] to_upper(input logic [4:0] idx);
    return 7'(CHAR_UPPER_A + 7'(idx));
  endfunction

endpackage

// ===== hw/rtl/pfe_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing; used for the letter position and square tables.
module pfe_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pfe_fifo.sv =====
// Small register queue with push/full and pop/empty handshakes.
// Depends on nothing; used between front and back and at the result side.
module pfe_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : PtrW'(wptr + PtrW'(1));
      end
      if (do_pop) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : PtrW'(rptr + PtrW'(1));
      end
      if (do_push && !do_pop) begin
        count <= CntW'(count + CntW'(1));
      end else if (!do_push && do_pop) begin
        count <= CntW'(count - CntW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/pfe_front.sv =====
// Front end: holds one command, builds the key square and pairs text letters.
// Depends on pfe_pkg and assert_macros.svh; emits pair jobs and table writes.
`include "assert_macros.svh"

module pfe_front import pfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [2:0] command,
  input  logic [7:0] letter_byte,
  output logic       full,
  output pfe_job_t   job,
  output logic       job_push,
  input  logic       job_full,
  input  logic       back_idle,
  output pfe_wr_t    wr
);

  pfe_front_state_t state;
  pfe_front_state_t state_next;

  logic        hv;
  logic [2:0]  hcmd;
  logic [7:0]  hbyte;
  logic [4:0]  fill_idx;
  logic [4:0]  fill_idx_next;
  logic [2:0]  fill_row;
  logic [2:0]  fill_col;
  logic [4:0]  fill_cell;
  logic [25:0] placed;
  logic [4:0]  pend;
  logic [4:0]  pend_next;
  logic        pend_v;
  logic        pend_v_next;

  logic       take;
  logic       clr;
  logic       is_letter;
  logic [4:0] hidx;
  logic       full_sq;
  logic       place_req;
  logic [4:0] place_idx;
  logic       place_ok;
  logic       fill_pos_ok;

  assign is_letter = (hbyte inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) && (hbyte != CHAR_LOWER_Q);
  assign hidx = 5'(hbyte - CHAR_LOWER_A);
  assign full_sq = (fill_row == SIDE_END);
  assign full = hv && !take;

  always_comb begin
    state_next = state;
    fill_idx_next = fill_idx;
    pend_next = pend;
    pend_v_next = pend_v;
    take = 1'b0;
    clr = 1'b0;
    place_req = 1'b0;
    place_idx = hidx;
    job_push = 1'b0;
    job.first = pend;
    job.second = hidx;
    job.sq_full = full_sq;
    case (state)
      FS_RUN: begin
        if (hv) begin
          case (pfe_cmd_t'(hcmd))
            CMD_CLEAR: begin
              take = 1'b1;
              clr = 1'b1;
              pend_next = '0;
              pend_v_next = 1'b0;
            end
            CMD_KEY: begin
              if (back_idle) begin
                take = 1'b1;
                place_req = is_letter;
              end
            end
            CMD_KEY_DONE: begin
              if (back_idle) begin
                if (full_sq) begin
                  take = 1'b1;
                end else begin
                  state_next = FS_FILL;
                  fill_idx_next = '0;
                end
              end
            end
            CMD_TEXT: begin
              if (!is_letter) begin
                take = 1'b1;
              end else if (!pend_v) begin
                take = 1'b1;
                pend_next = hidx;
                pend_v_next = 1'b1;
              end else if (!job_full) begin
                take = 1'b1;
                job_push = 1'b1;
                job.second = (pend == hidx) ? LETTER_X : hidx;
                pend_next = hidx;
                pend_v_next = (pend == hidx);
              end
            end
            CMD_END: begin
              if (!pend_v) begin
                take = 1'b1;
              end else if (!job_full) begin
                take = 1'b1;
                job_push = 1'b1;
                job.second = LETTER_X;
                pend_v_next = 1'b0;
              end
            end
            default: begin
              take = 1'b1;
            end
          endcase
        end
      end
      FS_FILL: begin
        place_req = 1'b1;
        place_idx = fill_idx;
        fill_idx_next = 5'(fill_idx + 5'd1);
        if (fill_idx == LETTER_LAST) begin
          take = 1'b1;
          state_next = FS_RUN;
        end
      end
      default: begin
        state_next = FS_RUN;
      end
    endcase
  end

  assign place_ok = place_req && (place_idx != LETTER_Q) && !placed[place_idx] && !full_sq;

  assign wr.we = place_ok;
  assign wr.letter = place_idx;
  assign wr.pos = {fill_row, fill_col};
  assign wr.slot = fill_cell;

  assign fill_pos_ok = (fill_col != 3'd0) && (fill_col <= SIDE_LAST) &&
                       (fill_row != 3'd0) && (fill_row <= SIDE_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      fill_idx <= '0;
      fill_row <= 3'd1;
      fill_col <= 3'd1;
      fill_cell <= '0;
      placed <= '0;
      pend <= '0;
      pend_v <= 1'b0;
    end else begin
      if (push && !full) begin
        hv <= 1'b1;
      end else if (take) begin
        hv <= 1'b0;
      end
      fill_idx <= fill_idx_next;
      pend <= pend_next;
      pend_v <= pend_v_next;
      if (clr) begin
        fill_row <= 3'd1;
        fill_col <= 3'd1;
        fill_cell <= '0;
        placed <= '0;
      end else if (place_ok) begin
        placed[place_idx] <= 1'b1;
        fill_cell <= 5'(fill_cell + 5'd1);
        if (fill_col == SIDE_LAST) begin
          fill_col <= 3'd1;
          fill_row <= 3'(fill_row + 3'd1);
        end else begin
          fill_col <= 3'(fill_col + 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      hcmd <= command;
      hbyte <= letter_byte;
    end
  end

  `ASSERT_IMPLY(a_write_drained, clk, rst, wr.we, back_idle, "square written with pairs out")
  `ASSERT_IMPLY(a_fill_no_job, clk, rst, state == FS_FILL, !job_push, "pair issued during fill")
  `ASSERT_ALWAYS(a_fill_pos, clk, rst, fill_pos_ok, "fill position out of range")

endmodule

// ===== hw/rtl/pfe_back.sv =====
// Back end: looks up a pair's letters and reads the cipher letters from a full square.
// Depends on pfe_pkg, pfe_ram and assert_macros.svh.
`include "assert_macros.svh"

module pfe_back import pfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  pfe_job_t job,
  input  logic     job_valid,
  output logic     job_pop,
  input  pfe_wr_t  wr,
  output pfe_res_t res,
  output logic     res_valid,
  input  logic     res_ready,
  output logic     idle
);

  logic       v1;
  logic [4:0] first1;
  logic [4:0] second1;
  logic       full1;
  logic       v2;
  logic [4:0] first2;
  logic [4:0] second2;
  logic       full2;

  logic [5:0] pos_a;
  logic [5:0] pos_b;
  logic [4:0] cell_a;
  logic [4:0] cell_b;
  logic [4:0] addr_a;
  logic [4:0] addr_b;
  logic [2:0] r1;
  logic [2:0] k1;
  logic [2:0] r2;
  logic [2:0] k2;
  logic       ready2;
  logic       move12;

  assign ready2 = !v2 || res_ready;
  assign move12 = v1 && ready2;
  assign job_pop = job_valid && (!v1 || ready2);
  assign idle = !v1 && !v2;

  pfe_ram #(.Width(6), .Depth(NUM_LETTERS)) u_pos_a (
    .clk(clk), .we(wr.we), .waddr(wr.letter), .wdata(wr.pos),
    .re(job_pop), .raddr(job.first), .rdata(pos_a)
  );

  pfe_ram #(.Width(6), .Depth(NUM_LETTERS)) u_pos_b (
    .clk(clk), .we(wr.we), .waddr(wr.letter), .wdata(wr.pos),
    .re(job_pop), .raddr(job.second), .rdata(pos_b)
  );

  assign r1 = pos_a[5:3];
  assign k1 = pos_a[2:0];
  assign r2 = pos_b[5:3];
  assign k2 = pos_b[2:0];

  always_comb begin
    addr_a = '0;
    addr_b = '0;
    if (full1) begin
      if (r1 == r2) begin
        addr_a = cell_index(r1, wrap_next(k1));
        addr_b = cell_index(r2, wrap_next(k2));
      end else if (k1 == k2) begin
        addr_a = cell_index(wrap_next(r1), k1);
        addr_b = cell_index(wrap_next(r2), k2);
      end else begin
        addr_a = cell_index(r1, k2);
        addr_b = cell_index(r2, k1);
      end
    end
  end

  pfe_ram #(.Width(5), .Depth(NUM_CELLS)) u_cell_a (
    .clk(clk), .we(wr.we), .waddr(wr.slot), .wdata(wr.letter),
    .re(move12), .raddr(addr_a), .rdata(cell_a)
  );

  pfe_ram #(.Width(5), .Depth(NUM_CELLS)) u_cell_b (
    .clk(clk), .we(wr.we), .waddr(wr.slot), .wdata(wr.letter),
    .re(move12), .raddr(addr_b), .rdata(cell_b)
  );

  assign res_valid = v2;
  assign res.cipher_first = to_upper(full2 ? cell_a : first2);
  assign res.cipher_second = to_upper(full2 ? cell_b : second2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (job_pop) begin
        v1 <= 1'b1;
      end else if (move12) begin
        v1 <= 1'b0;
      end
      if (move12) begin
        v2 <= 1'b1;
      end else if (v2 && res_ready) begin
        v2 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      first1 <= job.first;
      second1 <= job.second;
      full1 <= job.sq_full;
    end
    if (move12) begin
      first2 <= first1;
      second2 <= second1;
      full2 <= full1;
    end
  end

  `ASSERT_IMPLY(a_pos_placed, clk, rst, v1 && full1, r1 != 3'd0 && r2 != 3'd0, "pair not placed")
  `ASSERT_NEXT(a_stage_hold, clk, rst, v1 && !ready2, v1, "stalled pair dropped")
  `ASSERT_NEXT(a_res_hold, clk, rst, v2 && !res_ready, v2 && $stable(res), "stalled result changed")

endmodule

// ===== hw/rtl/playfair_pair_encrypt_unit.sv =====
// Playfair pair encryptor: pairs pass the input register, job queue, back-end position and cell
// reads, and result queue. Text bytes stream one per cycle while the job queue has room; a key
// byte waits until pairs in flight leave the back end. Key done on an unfilled square walks all
// 26 letters, one a cycle, holding the input. Synchronous reset empties both queues, the square
// and the pending letter; no clearing pass. Depends on pfe_pkg, pfe_front, pfe_fifo and pfe_back.
module playfair_pair_encrypt_unit import pfe_pkg::*; #(
  parameter int JobDepth = JOB_DEPTH,
  parameter int OutDepth = OUT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] command,
  input  logic [7:0] letter_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] cipher_first,
  output logic [6:0] cipher_second
);

  pfe_job_t job_in;
  pfe_job_t job_out;
  pfe_wr_t  wr;
  pfe_res_t res;
  pfe_res_t res_out;
  logic     job_push;
  logic     job_full;
  logic     job_empty;
  logic     job_pop;
  logic     back_idle;
  logic     res_valid;
  logic     out_full;

  pfe_front u_front (
    .clk(clk), .rst(rst), .push(push), .command(command), .letter_byte(letter_byte),
    .full(full), .job(job_in), .job_push(job_push), .job_full(job_full),
    .back_idle(job_empty && back_idle), .wr(wr)
  );

  pfe_fifo #(.Width($bits(pfe_job_t)), .Depth(JobDepth)) u_job_q (
    .clk(clk), .rst(rst), .push(job_push), .wdata(job_in), .full(job_full),
    .pop(job_pop), .rdata(job_out), .empty(job_empty)
  );

  pfe_back u_back (
    .clk(clk), .rst(rst), .job(job_out), .job_valid(!job_empty), .job_pop(job_pop),
    .wr(wr), .res(res), .res_valid(res_valid), .res_ready(!out_full), .idle(back_idle)
  );

  pfe_fifo #(.Width($bits(pfe_res_t)), .Depth(OutDepth)) u_out_q (
    .clk(clk), .rst(rst), .push(res_valid), .wdata(res), .full(out_full),
    .pop(pop), .rdata(res_out), .empty(empty)
  );

  assign cipher_first = res_out.cipher_first;
  assign cipher_second = res_out.cipher_second;

endmodule
